// ----- design/ald_pkg.sv -----
// ----------------------------------------------------------------------------
// ald_pkg
// Shared constants and types for the anti-aliased line drawer.
// ----------------------------------------------------------------------------
package ald_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 8;
  localparam int GRAD_BITS = 16;
  localparam int YQ        = FRAC_BITS + GRAD_BITS;
  localparam int DIV_STEPS = 16 + GRAD_BITS;

  // Framebuffer geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int PIX_BITS   = 24;

  // Operation codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Register select (paddr bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Framebuffer write port
  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [PIX_BITS-1:0]  data;
  } fb_wr_t;

  // Framebuffer read port
  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
  } fb_rd_t;

endpackage

// ----- design/ald_fb.sv -----
// ----------------------------------------------------------------------------
// ald_fb
// Pixel store: one write port, one registered read port, and a clearing
// sweep that zeroes every entry after reset.
// ----------------------------------------------------------------------------
module ald_fb (
  input  logic                          clk,
  input  logic                          rst,
  input  ald_pkg::fb_wr_t               wr,
  input  ald_pkg::fb_rd_t               rd,
  output logic [ald_pkg::PIX_BITS-1:0]  rd_data,
  output logic                          clearing
);
  import ald_pkg::*;

  logic [PIX_BITS-1:0]  mem [DEPTH];
  logic [ADDR_BITS-1:0] clr_addr;

  // clearing sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clearing <= 1'b0;
    end
  end

  // storage array
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) rd_data <= mem[rd.addr];
  end

endmodule

// ----- design/ald_div.sv -----
// ----------------------------------------------------------------------------
// ald_div
// Restoring divider for the gradient: (num << GRAD_BITS) / den, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module ald_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [16:0] quo
);
  import ald_pkg::*;

  logic [DIV_STEPS-1:0] dvd;
  logic [16:0]          rem;
  logic [5:0]           cnt;
  logic                 busy;
  logic [17:0]          trial;
  logic [17:0]          diff;
  logic                 ge;

  // one trial subtract per step
  always_comb begin
    trial = {rem, dvd[DIV_STEPS-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {num, {GRAD_BITS{1'b0}}};
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[16:0] : trial[16:0];
      dvd <= {dvd[DIV_STEPS-2:0], ge};
    end
  end

  assign quo = dvd[16:0];

endmodule

// ----- design/antialiased_line_draw_top.sv -----
// ----------------------------------------------------------------------------
// antialiased_line_draw_top
// Anti-aliased line drawer into a 64x64 RGB framebuffer, with pixel read.
//
//  channel   dir  transfer when                 payload
//  s_*       in   s_tvalid & s_tready           draw or read request
//  m_*       out  m_tvalid & m_tready           pixel read / write count
//  apb       in   psel & penable & pwrite       active_width, active_height
//
// Read: the request passes the read state and the final state before m_tvalid.
// Draw: setup, then the gradient divider (skipped when dx is zero), then two
// pixel writes per plotted column through the shared multiply stage; columns
// left of the image only advance. Columns past the framebuffer edge end the
// draw. After reset a clearing sweep zeroes the framebuffer; no transfer is
// taken meanwhile. A waiting result holds the sequencer in its final state
// until taken.
// ----------------------------------------------------------------------------
module antialiased_line_draw_top (
  input  logic         clk,
  input  logic         rst,
  // start_x[15:0] start_y[31:16] end_x[47:32] end_y[63:48] red[71:64]
  // green[79:72] blue[87:80] read_col[93:88] read_row[99:94]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic         s_tuser,   // operation[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // pixel_red[7:0] pixel_green[15:8] pixel_blue[23:16] writes_done[31:24]
  output logic [31:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ald_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_READ  = 11'b00000000010,
    ST_SETUP = 11'b00000000100,
    ST_DIVGO = 11'b00000001000,
    ST_DIV   = 11'b00000010000,
    ST_POS   = 11'b00000100000,
    ST_CG    = 11'b00001000000,
    ST_MUL   = 11'b00010000000,
    ST_WR    = 11'b00100000000,
    ST_STEP  = 11'b01000000000,
    ST_DONE  = 11'b10000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_EP1  = 3'b001,
    PH_EP2  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  localparam int PSHIFT = YQ + FRAC_BITS;

  function automatic logic signed [9:0] round_pix(input logic signed [15:0] v);
    logic [16:0] mag;
    logic [16:0] sh;
    mag = v[15] ? 17'(-17'(v)) : 17'(v);
    sh  = (mag + 17'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[15] ? 10'(-sh) : 10'(sh);
  endfunction

  state_t state;
  phase_t phase;

  logic [6:0] active_width, active_height;

  // latched request
  logic signed [15:0] lx0, ly0, lx1, ly1;
  logic [7:0]         cr, cgn, cb;

  // setup results
  logic               steep;
  logic signed [15:0] sx0, sy0, sx1, sy1;
  logic [16:0]        dx;
  logic [15:0]        dyabs;
  logic               dneg;
  logic signed [17:0] grad;

  // walk state
  logic signed [9:0]  xe1, xe2, xcur;
  logic signed [39:0] ycur;
  logic signed [9:0]  pair_major;
  logic signed [39:0] pair_y;
  logic [8:0]         pair_gap;

  // pixel pair stage
  logic signed [15:0] yp;
  logic [23:0]        fq;
  logic [24:0]        rq;
  logic [16:0]        cg_r, cg_g, cg_b;
  logic               half;
  logic [7:0]         pr, pg, pb;
  logic signed [16:0] pcol, prow;

  // result
  logic [7:0]         count;
  logic [PIX_BITS-1:0] res_pix;

  // submodule links
  fb_wr_t              fb_wr;
  fb_rd_t              fb_rd;
  logic [PIX_BITS-1:0] fb_rdata;
  logic                clearing;
  logic                div_start, div_done;
  logic [16:0]         div_quo;

  logic s_fire;
  assign s_tready = state == ST_IDLE && !clearing;
  assign s_fire   = s_tvalid && s_tready;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {25'b0, active_width};
      REG_HEIGHT: prdata = {25'b0, active_height};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= 7'(MAX_WIDTH);
      active_height <= 7'(MAX_HEIGHT);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_WIDTH:  active_width  <= pwdata[6:0];
        REG_HEIGHT: active_height <= pwdata[6:0];
        default:    ;
      endcase
    end
  end

  // setup: axis swap and endpoint ordering
  logic signed [16:0] ddx, ddy, o_dx, o_dy;
  logic [16:0]        adx, ady;
  logic               steep_c, swap_c;
  logic signed [15:0] a0, b0, a1, b1, o_x0, o_y0, o_x1, o_y1;
  always_comb begin
    ddx     = 17'(lx1) - 17'(lx0);
    ddy     = 17'(ly1) - 17'(ly0);
    adx     = ddx[16] ? 17'(-ddx) : 17'(ddx);
    ady     = ddy[16] ? 17'(-ddy) : 17'(ddy);
    steep_c = ady > adx;
    a0      = steep_c ? ly0 : lx0;
    b0      = steep_c ? lx0 : ly0;
    a1      = steep_c ? ly1 : lx1;
    b1      = steep_c ? lx1 : ly1;
    swap_c  = a0 > a1;
    o_x0    = swap_c ? a1 : a0;
    o_y0    = swap_c ? b1 : b0;
    o_x1    = swap_c ? a0 : a1;
    o_y1    = swap_c ? b0 : b1;
    o_dx    = 17'(o_x1) - 17'(o_x0);
    o_dy    = 17'(o_y1) - 17'(o_y0);
  end

  // endpoint position and walk step
  logic signed [15:0] pos_x, pos_y;
  logic signed [9:0]  pos_xe, pos_diff;
  logic signed [27:0] pos_prod;
  logic signed [39:0] pos_ye, step;
  logic [7:0]         gap_lo;
  logic [8:0]         pos_gap;
  logic signed [9:0]  major_lim;
  always_comb begin
    pos_x     = (phase == PH_EP1) ? sx0 : sx1;
    pos_y     = (phase == PH_EP1) ? sy0 : sy1;
    pos_xe    = round_pix(pos_x);
    pos_diff  = 10'((19'(pos_xe) <<< FRAC_BITS) - 19'(pos_x));
    pos_prod  = grad * pos_diff;
    pos_ye    = (40'(pos_y) <<< GRAD_BITS) + 40'(pos_prod);
    gap_lo    = pos_x[7:0] + 8'(1 << (FRAC_BITS - 1));
    pos_gap   = (phase == PH_EP1) ? 9'(9'(1 << FRAC_BITS) - {1'b0, gap_lo})
                                  : {1'b0, gap_lo};
    step      = 40'(grad) <<< FRAC_BITS;
    major_lim = steep ? 10'(MAX_HEIGHT) : 10'(MAX_WIDTH);
  end

  // coverage multiply and pixel coordinates
  logic [24:0]        frac;
  logic [41:0]        prod_r, prod_g, prod_b;
  logic signed [16:0] minor;
  always_comb begin
    frac   = half ? {1'b0, fq} : rq;
    prod_r = cg_r * frac;
    prod_g = cg_g * frac;
    prod_b = cg_b * frac;
    minor  = 17'(yp) + {16'b0, half};
  end

  // range check and write
  logic [6:0] eff_w, eff_h;
  logic       in_range;
  always_comb begin
    eff_w    = (active_width  > 7'(MAX_WIDTH))  ? 7'(MAX_WIDTH)  : active_width;
    eff_h    = (active_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : active_height;
    in_range = !pcol[16] && !prow[16] &&
               (pcol < $signed({10'b0, eff_w})) && (prow < $signed({10'b0, eff_h}));
    fb_wr.en   = state == ST_WR && in_range;
    fb_wr.addr = {prow[ROW_BITS-1:0], pcol[COL_BITS-1:0]};
    fb_wr.data = {pr, pg, pb};
    fb_rd.en   = s_fire && s_tuser == OP_READ;
    fb_rd.addr = {s_tdata[99:94], s_tdata[93:88]};
  end

  assign div_start = state == ST_DIVGO && dx != '0;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_EP1;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            state <= (s_tuser == OP_READ) ? ST_READ : ST_SETUP;
          end
        end
        ST_READ:  state <= ST_DONE;
        ST_SETUP: state <= ST_DIVGO;
        ST_DIVGO: begin
          phase <= PH_EP1;
          state <= (dx == '0) ? ST_POS : ST_DIV;
        end
        ST_DIV: if (div_done) state <= ST_POS;
        ST_POS: begin
          if (phase != PH_BODY) begin
            state <= ST_CG;
          end else if (xcur >= xe2 || xcur >= major_lim) begin
            state <= ST_DONE;
          end else if (!xcur[9]) begin
            state <= ST_CG;
          end
        end
        ST_CG:  state <= ST_MUL;
        ST_MUL: state <= ST_WR;
        ST_WR:  state <= half ? ST_STEP : ST_MUL;
        ST_STEP: begin
          if (phase == PH_EP1) phase <= PH_EP2;
          else phase <= PH_BODY;
          state <= ST_POS;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        lx0     <= s_tdata[15:0];
        ly0     <= s_tdata[31:16];
        lx1     <= s_tdata[47:32];
        ly1     <= s_tdata[63:48];
        cr      <= s_tdata[71:64];
        cgn     <= s_tdata[79:72];
        cb      <= s_tdata[87:80];
        count   <= '0;
        res_pix <= '0;
      end
      ST_READ: res_pix <= fb_rdata;
      ST_SETUP: begin
        steep <= steep_c;
        sx0   <= o_x0;
        sy0   <= o_y0;
        sx1   <= o_x1;
        sy1   <= o_y1;
        dx    <= o_dx;
        dyabs <= o_dy[16] ? 16'(-o_dy) : o_dy[15:0];
        dneg  <= o_dy[16];
      end
      ST_DIVGO: if (dx == '0) grad <= 18'(1 << GRAD_BITS);
      ST_DIV:   if (div_done) grad <= dneg ? -$signed({1'b0, div_quo})
                                           : $signed({1'b0, div_quo});
      ST_POS: begin
        half <= 1'b0;
        case (phase)
          PH_EP1: begin
            xe1        <= pos_xe;
            xe2        <= round_pix(sx1);
            ycur       <= pos_ye;
            pair_major <= pos_xe;
            pair_y     <= pos_ye;
            pair_gap   <= pos_gap;
          end
          PH_EP2: begin
            pair_major <= pos_xe;
            pair_y     <= pos_ye;
            pair_gap   <= pos_gap;
          end
          default: begin
            pair_major <= xcur;
            pair_y     <= ycur;
            pair_gap   <= 9'(1 << FRAC_BITS);
            // columns left of the image only advance
            if (xcur[9] && xcur < xe2) begin
              xcur <= xcur + 1'b1;
              ycur <= ycur + step;
            end
          end
        endcase
      end
      ST_CG: begin
        yp   <= pair_y[39:YQ];
        fq   <= pair_y[YQ-1:0];
        rq   <= 25'(1 << YQ) - {1'b0, pair_y[YQ-1:0]};
        cg_r <= cr  * pair_gap;
        cg_g <= cgn * pair_gap;
        cg_b <= cb  * pair_gap;
      end
      ST_MUL: begin
        pr   <= prod_r[PSHIFT+7:PSHIFT];
        pg   <= prod_g[PSHIFT+7:PSHIFT];
        pb   <= prod_b[PSHIFT+7:PSHIFT];
        pcol <= steep ? minor : 17'(pair_major);
        prow <= steep ? 17'(pair_major) : minor;
      end
      ST_WR: begin
        half <= 1'b1;
        if (in_range && count != 8'hFF) count <= count + 1'b1;
      end
      ST_STEP: begin
        case (phase)
          PH_EP1: ;
          PH_EP2: begin
            xcur <= xe1 + 1'b1;
            ycur <= ycur + step;
          end
          default: begin
            xcur <= xcur + 1'b1;
            ycur <= ycur + step;
          end
        endcase
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {count, res_pix[7:0], res_pix[15:8], res_pix[23:16]};
        end
      end
      default: ;
    endcase
  end

  ald_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dyabs),
    .den   (dx),
    .done  (div_done),
    .quo   (div_quo)
  );

  ald_fb u_fb (
    .clk      (clk),
    .rst      (rst),
    .wr       (fb_wr),
    .rd       (fb_rd),
    .rd_data  (fb_rdata),
    .clearing (clearing)
  );

  // checks
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("transfer accepted during clear");
  a_write_in_wr: assert property (@(posedge clk) disable iff (rst)
    fb_wr.en |-> state == ST_WR) else $error("framebuffer write outside write step");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV) else $error("divider finished out of turn");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> state == ST_DONE)
    else $error("result overwritten while stalled");

endmodule
